>>> hdl/lkvc_pkg.sv
// lkvc_pkg: shared constants, operation codes and the cell control struct
// for the lru key-value cache. Depends on nothing.

package lkvc_pkg;

    // built size of the cell row
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             upd;        // cells up to limit take their neighbor
        logic [IDX_W-1:0] limit;      // last cell position that shifts
        logic             set_valid;  // rewrite valid bits from new_fill
        logic [CNT_W-1:0] new_fill;   // cells below this position are valid
    } ctrl_t;

endpackage

>>> hdl/lkvc_if.sv
// lkvc_if: valid/ready channel interfaces of the lru key-value cache
// (request, response and capacity write). Depends on lkvc_pkg.

interface lkvc_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic signed [lkvc_pkg::KEY_W-1:0]  lookup_key;
    logic signed [lkvc_pkg::VAL_W-1:0]  write_value;

    modport source (output valid, output func, output lookup_key,
                    output write_value, input ready);
    modport sink   (input valid, input func, input lookup_key,
                    input write_value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic signed [lkvc_pkg::VAL_W-1:0]  read_value;
    logic                               evicted;

    modport source (output valid, output hit, output read_value,
                    output evicted, input ready);
    modport sink   (input valid, input hit, input read_value,
                    input evicted, output ready);
endinterface

interface lkvc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lkvc_pkg::CAP_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/lru_key_value_cache.sv
// lru_key_value_cache: top level; row of lkvc_cell, hit selection, fill
// count, capacity register and response register.
// Depends on lkvc_pkg, lkvc_if and lkvc_cell.
//
// Usage:
//   req carries one request: func (get or put), lookup_key, write_value.
//   rsp returns one response per request: hit, read_value (value on a get
//   hit, -1 on a get miss, 0 for a put) and evicted (a put miss that pushed
//   out the least recent entry).
//   cfg writes capacity_in_use; it is always ready. The user must see that it
//   is written only while no request is outstanding; the block itself does not
//   enforce this. Zero acts as one, values above the built size act as the built size.
// Timing:
//   the response to an accepted request is held in the response register.
//   One request per cycle is sustained while the receiver takes each response:
//   all cells compare the key in the same cycle and the row shifts by one
//   position in the cycle the request is accepted, so the cell row sets the rate.
//   When the receiver stalls, the response waits in its register and req
//   stays ready only if that register is emptied in the same cycle.
// Reset:
//   all cells become invalid, the fill count goes to zero and the capacity
//   returns to the built size of sixteen. No clearing pass is needed.

module lru_key_value_cache
(
    input  logic        clk,
    input  logic        rst_n,
    lkvc_req_if.sink    req,
    lkvc_rsp_if.source  rsp,
    lkvc_cfg_if.sink    cfg
);

    localparam int N = lkvc_pkg::MAX_ENTRIES;

    logic [lkvc_pkg::CAP_W-1:0]         capacity_reg;
    logic [lkvc_pkg::CNT_W-1:0]         fill_count_reg;
    logic [lkvc_pkg::CNT_W-1:0]         fill_count_next;

    logic                               rsp_valid_reg;
    logic                               hit_reg;
    logic signed [lkvc_pkg::VAL_W-1:0]  read_value_reg;
    logic                               evicted_reg;
    logic                               hit_next;
    logic signed [lkvc_pkg::VAL_W-1:0]  read_value_next;
    logic                               evicted_next;

    logic                               accept;
    logic [N-1:0]                       match_vec;
    logic [N-1:0]                       first_vec;
    logic [N-1:0]                       valid_vec;
    logic signed [lkvc_pkg::KEY_W-1:0]  key_vec   [N];
    logic signed [lkvc_pkg::VAL_W-1:0]  value_vec [N];
    logic signed [lkvc_pkg::KEY_W-1:0]  prev_key  [N];
    logic signed [lkvc_pkg::VAL_W-1:0]  prev_value [N];

    logic                               any_hit;
    logic                               seen;
    logic [lkvc_pkg::IDX_W-1:0]         hit_pos;
    logic signed [lkvc_pkg::VAL_W-1:0]  hit_value;
    logic [lkvc_pkg::EXT_W-1:0]         eff_cap;
    logic [lkvc_pkg::EXT_W-1:0]         fill_ext;
    logic                               full;
    logic [lkvc_pkg::IDX_W-1:0]         miss_limit;
    logic [lkvc_pkg::CNT_W-1:0]         miss_fill;
    logic signed [lkvc_pkg::VAL_W-1:0]  front_value;
    lkvc_pkg::ctrl_t                    ctrl;

    // handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            capacity_reg <= cfg.data;
        end
    end

    // first matching cell and its value
    always_comb
    begin
        seen      = 1'b0;
        hit_pos   = '0;
        hit_value = '0;
        first_vec = '0;
        for (int i = 0; i < N; i++)
        begin
            first_vec[i] = match_vec[i] && !seen;
            seen         = seen || match_vec[i];
            if (first_vec[i])
            begin
                hit_pos = lkvc_pkg::IDX_W'(i);
            end
            hit_value = hit_value | (value_vec[i] & {lkvc_pkg::VAL_W{first_vec[i]}});
        end
    end

    assign any_hit = |match_vec;

    // effective capacity and insert position
    always_comb
    begin
        eff_cap = lkvc_pkg::EXT_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            eff_cap = lkvc_pkg::EXT_W'(1);
        end
        else if (lkvc_pkg::EXT_W'(capacity_reg) > lkvc_pkg::EXT_W'(N))
        begin
            eff_cap = lkvc_pkg::EXT_W'(N);
        end
    end

    assign fill_ext = lkvc_pkg::EXT_W'(fill_count_reg);
    assign full     = (fill_ext >= eff_cap);

    always_comb
    begin
        if (full)
        begin
            miss_limit = lkvc_pkg::IDX_W'(eff_cap - lkvc_pkg::EXT_W'(1));
            miss_fill  = lkvc_pkg::CNT_W'(eff_cap);
        end
        else
        begin
            miss_limit = lkvc_pkg::IDX_W'(fill_count_reg);
            miss_fill  = fill_count_reg + lkvc_pkg::CNT_W'(1);
        end
    end

    // broadcast control to the cell row
    always_comb
    begin
        ctrl.upd       = accept && (any_hit || (req.func == lkvc_pkg::FUNC_PUT));
        ctrl.limit     = any_hit ? hit_pos : miss_limit;
        ctrl.set_valid = accept && (req.func == lkvc_pkg::FUNC_PUT) && !any_hit;
        ctrl.new_fill  = miss_fill;
    end

    assign front_value = (req.func == lkvc_pkg::FUNC_PUT) ? req.write_value : hit_value;

    // cell row: cell 0 takes the request, each other cell its neighbor
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_front
                assign prev_key[g]   = req.lookup_key;
                assign prev_value[g] = front_value;
            end
            else
            begin : g_chain
                assign prev_key[g]   = key_vec[g-1];
                assign prev_value[g] = value_vec[g-1];
            end

            lkvc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (lkvc_pkg::IDX_W'(g)),
                .ctrl       (ctrl),
                .lookup_key (req.lookup_key),
                .prev_key   (prev_key[g]),
                .prev_value (prev_value[g]),
                .match      (match_vec[g]),
                .valid      (valid_vec[g]),
                .key        (key_vec[g]),
                .value      (value_vec[g])
            );
        end
    endgenerate

    // fill count
    assign fill_count_next = ctrl.set_valid ? miss_fill : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // response fields
    always_comb
    begin
        hit_next     = any_hit;
        evicted_next = 1'b0;
        if (req.func == lkvc_pkg::FUNC_PUT)
        begin
            read_value_next = '0;
            evicted_next    = !any_hit && full;
        end
        else if (any_hit)
        begin
            read_value_next = hit_value;
        end
        else
        begin
            read_value_next = lkvc_pkg::MISS_VALUE;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg        <= hit_next;
            read_value_reg <= read_value_next;
            evicted_reg    <= evicted_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.evicted    = evicted_reg;

    // keys are unique among valid cells
    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the request key");

    // the number of valid cells equals the fill count
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_count_reg))
        else $error("valid cell count differs from fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= lkvc_pkg::CNT_W'(N))
        else $error("fill count above built size");

    // an eviction only comes from a put miss
    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && evicted_reg |-> !hit_reg)
        else $error("eviction reported on a hit");

    // each accepted request leaves a response in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

endmodule

>>> hdl/lkvc_cell.sv
// lkvc_cell: one position of the recency-ordered cell row; holds a key,
// a value and a valid bit. Depends on lkvc_pkg.

module lkvc_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lkvc_pkg::IDX_W-1:0]         cell_idx,
    input  lkvc_pkg::ctrl_t                    ctrl,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  prev_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0]  prev_value,
    output logic                               match,
    output logic                               valid,
    output logic signed [lkvc_pkg::KEY_W-1:0]  key,
    output logic signed [lkvc_pkg::VAL_W-1:0]  value
);

    logic signed [lkvc_pkg::KEY_W-1:0] key_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              shift;

    // key compare against the broadcast request key
    assign match = valid_reg && (key_reg == lookup_key);
    assign shift = ctrl.upd && (cell_idx <= ctrl.limit);

    // valid bit follows the new fill count on an insert
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.set_valid)
        begin
            valid_next = (lkvc_pkg::CNT_W'(cell_idx) < ctrl.new_fill);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload moves one position back toward the least recent end
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule
